/* src/kvma_pkg.sv */
// Shared types and constants for the multiplicity assignment block.
package kvma_pkg;

	localparam int SYM_W   = 4;
	localparam int POS_W   = 4;
	localparam int CELL_W  = SYM_W + POS_W;
	localparam int CELLS   = 1 << CELL_W;
	localparam int RELI_W  = 16;
	localparam int MULT_W  = 8;
	localparam int COST_W  = 24;
	localparam int CMD_W   = 2;
	localparam int CFG_W   = 8;
	localparam int CIDX_W  = 2;
	localparam int DCNT_W  = $clog2(RELI_W);
	localparam int DIVS_W  = MULT_W + 1;
	localparam int TB_W    = 2 * (CFG_W + 1 + CFG_W);
	localparam int XPR_W   = CFG_W + COST_W;

	localparam logic [MULT_W-1:0] MULT_MAX = '1;
	localparam logic [COST_W:0]   COST_MAX = {1'b0, {COST_W{1'b1}}};

	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_STOP_MODE   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_STEP_LIMIT  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_Y_WEIGHT    = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_INFO_LENGTH = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SQ,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_CHECK,
		ST_DIV,
		ST_COMMIT,
		ST_RESP
	} kvma_state_t;

	typedef struct packed {
		logic capture;
		logic load_we;
		logic rd_mult;
		logic run_init;
		logic sq;
		logic scan_start;
		logic scan_step;
		logic fetch;
		logic check;
		logic div_step;
		logic commit;
		logic resp;
	} kvma_cmd_t;

	typedef struct packed {
		logic stop_zero;
		logic scan_last;
		logic sat;
		logic div_last;
		logic stop_run;
		logic out_free;
	} kvma_stat_t;

endpackage

/* src/kvma_item_if.sv */
// Item and result channel interfaces.
interface kvma_item_if;
	import kvma_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [SYM_W-1:0]    symbol;
	logic [POS_W-1:0]    position;
	logic [RELI_W-1:0]   reliability;
	modport source (output valid, cmd, symbol, position, reliability, input ready);
	modport sink (input valid, cmd, symbol, position, reliability, output ready);
endinterface

interface kvma_result_if;
	import kvma_pkg::*;
	logic                valid;
	logic                ready;
	logic [MULT_W-1:0]   multiplicity;
	logic [COST_W-1:0]   total_cost;
	logic                overflow;
	modport source (output valid, multiplicity, total_cost, overflow, input ready);
	modport sink (input valid, multiplicity, total_cost, overflow, output ready);
endinterface

/* src/kvma_ctrl.sv */
// Controller state machine sequencing load, read and run items.
module kvma_ctrl import kvma_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic [CMD_W-1:0] item_cmd,
	output logic             item_ready,
	input  kvma_stat_t       stat,
	output kvma_cmd_t        cmd
);

	kvma_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = (item_cmd == CMD_RUN) ? ST_INIT : ST_RESP;
				end
			end
			ST_INIT:   state_d = stat.stop_zero ? ST_RESP : ST_SQ;
			ST_SQ:     state_d = ST_SCAN;
			ST_SCAN: begin
				if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_FETCH;
			ST_FETCH:  state_d = ST_CHECK;
			ST_CHECK:  state_d = stat.sat ? ST_RESP : ST_DIV;
			ST_DIV: begin
				if (stat.div_last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: state_d = stat.stop_run ? ST_RESP : ST_SCAN;
			ST_RESP: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
				cmd.load_we = item_valid && (item_cmd == CMD_LOAD);
				cmd.rd_mult = item_valid && (item_cmd == CMD_READ);
			end
			ST_INIT:   cmd.run_init = 1'b1;
			ST_SQ: begin
				cmd.sq         = 1'b1;
				cmd.scan_start = 1'b1;
			end
			ST_SCAN:   cmd.scan_step = 1'b1;
			ST_DRAIN:  cmd = '0;
			ST_FETCH:  cmd.fetch = 1'b1;
			ST_CHECK:  cmd.check = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_COMMIT: begin
				cmd.commit     = 1'b1;
				cmd.scan_start = 1'b1;
			end
			ST_RESP:   cmd.resp = stat.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

/* src/kvma_dpath.sv */
// Datapath: stores, scan, divider, stop test, configuration and result register.
module kvma_dpath import kvma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  kvma_cmd_t         cmd,
	output kvma_stat_t        stat,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [CMD_W-1:0]  item_cmd,
	input  logic [SYM_W-1:0]  item_symbol,
	input  logic [POS_W-1:0]  item_position,
	input  logic [RELI_W-1:0] item_reliability,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [MULT_W-1:0] res_multiplicity,
	output logic [COST_W-1:0] res_total_cost,
	output logic              res_overflow
);

	logic              stop_mode_q;
	logic [CFG_W-1:0]  step_limit_q, y_weight_q, info_length_q;

	logic [RELI_W-1:0] rel_mem [CELLS];
	logic [MULT_W-1:0] mult_mem [CELLS];
	logic [CELLS-1:0]  mult_vld_q;

	logic [RELI_W-1:0] rel_rd_s1;
	logic              rd_v_s1;
	logic [CELL_W-1:0] rd_addr_s1;
	logic [MULT_W-1:0] mult_rd_s1;
	logic              mult_vld_s1;

	logic [CELL_W-1:0] scan_q, pick_q;
	logic [RELI_W-1:0] best_q;
	logic [COST_W-1:0] cost_q, newcost_q;
	logic              ovf_q;
	logic [CFG_W-1:0]  count_q;
	logic [MULT_W-1:0] mnew_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [TB_W/2-1:0] tb_q;
	logic [TB_W-1:0]   t2_q;
	logic [XPR_W-1:0]  x_q;

	logic [RELI_W-1:0] dq_q;
	logic [DIVS_W:0]   dr_q;
	logic [DIVS_W-1:0] dd_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic [CELL_W-1:0] item_cell, mult_raddr;
	logic [MULT_W-1:0] m_cur;
	logic [COST_W:0]   cost_sum;
	logic [CFG_W-1:0]  yw_eff, km1;
	logic [DIVS_W:0]   dtrial;
	logic [XPR_W:0]    x2;
	logic              stop_run;
	logic              mult_we;

	assign item_cell  = {item_symbol, item_position};
	assign mult_raddr = cmd.fetch ? pick_q : item_cell;
	assign m_cur      = mult_vld_s1 ? mult_rd_s1 : '0;
	assign cost_sum   = {1'b0, cost_q} + {{(COST_W+1-MULT_W){1'b0}}, m_cur} + 1'b1;
	assign yw_eff     = (y_weight_q == '0) ? CFG_W'(1) : y_weight_q;
	assign km1        = (info_length_q > CFG_W'(1)) ? (info_length_q - 1'b1) : '0;
	assign dtrial     = {dr_q[DIVS_W-1:0], dq_q[RELI_W-1]};
	assign x2         = {x_q, 1'b0};
	assign stop_run   = stop_mode_q ? ((XPR_W+1 >= TB_W) ? (x2 >= (XPR_W+1)'(t2_q))
	                                                    : (TB_W'(x2) >= t2_q))
	                                : ({1'b0, count_q} + 1'b1 == {1'b0, step_limit_q});
	assign mult_we    = cmd.commit && !(stop_mode_q && stop_run);

	assign stat.stop_zero = !stop_mode_q && (step_limit_q == '0);
	assign stat.scan_last = (scan_q == CELL_W'(CELLS - 1));
	assign stat.sat       = (m_cur == MULT_MAX) || (cost_sum > COST_MAX);
	assign stat.div_last  = (dcnt_q == DCNT_W'(RELI_W - 1));
	assign stat.stop_run  = stop_run;
	assign stat.out_free  = !res_valid || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_mode_q   <= 1'b1;
			step_limit_q  <= CFG_W'(16);
			y_weight_q    <= CFG_W'(1);
			info_length_q <= CFG_W'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STOP_MODE:   stop_mode_q   <= cfg_data[0];
				CFG_STEP_LIMIT:  step_limit_q  <= cfg_data;
				CFG_Y_WEIGHT:    y_weight_q    <= cfg_data;
				CFG_INFO_LENGTH: info_length_q <= cfg_data;
				default:         stop_mode_q   <= stop_mode_q;
			endcase
		end
	end

	// reliability store: one write port, scan read port
	always_ff @(posedge clk) begin
		if (cmd.load_we) begin
			rel_mem[item_cell] <= item_reliability;
		end else if (cmd.commit) begin
			rel_mem[pick_q] <= dq_q;
		end
		rel_rd_s1  <= rel_mem[scan_q];
		rd_addr_s1 <= scan_q;
	end

	always_ff @(posedge clk) begin
		if (mult_we) begin
			mult_mem[pick_q] <= mnew_q;
		end
		if (cmd.rd_mult || cmd.fetch) begin
			mult_rd_s1 <= mult_mem[mult_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_vld_q  <= '0;
			mult_vld_s1 <= 1'b0;
			rd_v_s1     <= 1'b0;
			cost_q      <= '0;
			ovf_q       <= 1'b0;
			res_valid   <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan_step;
			if (cmd.run_init) begin
				mult_vld_q <= '0;
				cost_q     <= '0;
				ovf_q      <= 1'b0;
			end else if (mult_we) begin
				mult_vld_q[pick_q] <= 1'b1;
				cost_q             <= newcost_q;
			end
			if (cmd.rd_mult || cmd.fetch) begin
				mult_vld_s1 <= mult_vld_q[mult_raddr];
			end
			if (cmd.check && stat.sat) begin
				ovf_q <= 1'b1;
			end
			if (cmd.resp) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= item_cmd;
		end
		if (cmd.run_init) begin
			tb_q    <= (TB_W/2)'({1'b0, step_limit_q} + 1'b1) * (TB_W/2)'(yw_eff);
			count_q <= '0;
		end
		if (cmd.sq) begin
			t2_q <= TB_W'(tb_q) * TB_W'(tb_q);
		end
		// scan: track first strict maximum
		if (cmd.scan_start) begin
			scan_q <= '0;
			best_q <= '0;
			pick_q <= '0;
		end else begin
			if (cmd.scan_step) begin
				scan_q <= scan_q + 1'b1;
			end
			if (rd_v_s1 && (rel_rd_s1 > best_q)) begin
				best_q <= rel_rd_s1;
				pick_q <= rd_addr_s1;
			end
		end
		if (cmd.check) begin
			newcost_q <= cost_sum[COST_W-1:0];
			mnew_q    <= m_cur + 1'b1;
			dq_q      <= best_q;
			dr_q      <= '0;
			dd_q      <= {1'b0, m_cur} + DIVS_W'(2);
			dcnt_q    <= '0;
		end
		// restoring divide: one quotient bit per cycle
		if (cmd.div_step) begin
			x_q    <= XPR_W'(km1) * XPR_W'(newcost_q);
			dcnt_q <= dcnt_q + 1'b1;
			if (dtrial >= {1'b0, dd_q}) begin
				dr_q <= dtrial - {1'b0, dd_q};
				dq_q <= {dq_q[RELI_W-2:0], 1'b1};
			end else begin
				dr_q <= dtrial;
				dq_q <= {dq_q[RELI_W-2:0], 1'b0};
			end
		end
		if (cmd.commit) begin
			count_q <= count_q + 1'b1;
		end
		if (cmd.resp) begin
			res_multiplicity <= ((cmd_q == CMD_READ) && mult_vld_s1) ? mult_rd_s1 : '0;
			res_total_cost   <= cost_q;
			res_overflow     <= ovf_q;
		end
	end

endmodule

/* src/kv_multiplicity_assignment.sv */
// Load and read items are taken only in the idle state; one item is in work at a time, so a
// new item is taken only once the result of the last one is registered.
// A run item performs increments until its stop test holds or an increment saturates,
// and performs none when the step limit is zero in step-count mode: each increment scans
// every reliability entry through the single memory read port, then divides by a 16-step
// restoring divider. A stalled result channel holds the block in its result state.
// Reset clears control state, configuration to its defaults, all multiplicities (their valid
// bits, so they read as zero), cost and overflow; reliabilities are undefined until loaded.
module kv_multiplicity_assignment import kvma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	kvma_item_if.sink         item_ch,
	kvma_result_if.source     result_ch,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	kvma_cmd_t  cmd;
	kvma_stat_t stat;

	kvma_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_ch.valid),
		.item_cmd   (item_ch.cmd),
		.item_ready (item_ch.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	kvma_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.item_cmd         (item_ch.cmd),
		.item_symbol      (item_ch.symbol),
		.item_position    (item_ch.position),
		.item_reliability (item_ch.reliability),
		.res_valid        (result_ch.valid),
		.res_ready        (result_ch.ready),
		.res_multiplicity (result_ch.multiplicity),
		.res_total_cost   (result_ch.total_cost),
		.res_overflow     (result_ch.overflow)
	);

endmodule
